// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/ocvsoc_pkg.sv
// types and constants for the ocv state-of-charge block
// no dependencies
package ocvsoc_pkg;
  localparam int MvW = 15;
  localparam int PctW = 7;
  localparam int SrcW = 2;

  localparam logic [1:0] SRC_LIVE = 2'd0;
  localparam logic [1:0] SRC_REST = 2'd1;
  localparam logic [1:0] SRC_NONE = 2'd2;

  localparam logic [1:0] CHG_OFF = 2'd0;
  localparam logic [1:0] CHG_ON = 2'd1;
  localparam logic [1:0] CHG_FAIL = 2'd2;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  localparam int TableRows = 31;

  // per-stage item carried down the pipe
  typedef struct packed {
    logic [SrcW-1:0] source;
    logic [MvW-1:0]  mv;
    logic            chg_present;
    logic            chg_ok;
  } stage_t;

  // table row voltage
  function automatic logic [MvW-1:0] row_mv(input logic [4:0] idx);
    logic [MvW-1:0] r;
    case (idx)
      5'd0: r = 15'd4167;  5'd1: r = 15'd4112;  5'd2: r = 15'd4072;
      5'd3: r = 15'd4025;  5'd4: r = 15'd3984;  5'd5: r = 15'd3957;
      5'd6: r = 15'd3929;  5'd7: r = 15'd3900;  5'd8: r = 15'd3858;
      5'd9: r = 15'd3827;  5'd10: r = 15'd3807; 5'd11: r = 15'd3792;
      5'd12: r = 15'd3780; 5'd13: r = 15'd3772; 5'd14: r = 15'd3765;
      5'd15: r = 15'd3753; 5'd16: r = 15'd3731; 5'd17: r = 15'd3704;
      5'd18: r = 15'd3687; 5'd19: r = 15'd3683; 5'd20: r = 15'd3682;
      5'd21: r = 15'd3681; 5'd22: r = 15'd3680; 5'd23: r = 15'd3676;
      5'd24: r = 15'd3667; 5'd25: r = 15'd3638; 5'd26: r = 15'd3591;
      5'd27: r = 15'd3528; 5'd28: r = 15'd3445; 5'd29: r = 15'd3308;
      default: r = 15'd3000;
    endcase
    return r;
  endfunction

  // table row percent
  function automatic logic [PctW-1:0] row_pct(input logic [4:0] idx);
    logic [PctW-1:0] r;
    case (idx)
      5'd0: r = 7'd100; 5'd1: r = 7'd95;  5'd2: r = 7'd90;  5'd3: r = 7'd85;
      5'd4: r = 7'd80;  5'd5: r = 7'd75;  5'd6: r = 7'd70;  5'd7: r = 7'd65;
      5'd8: r = 7'd60;  5'd9: r = 7'd55;  5'd10: r = 7'd50; 5'd11: r = 7'd45;
      5'd12: r = 7'd40; 5'd13: r = 7'd35; 5'd14: r = 7'd30; 5'd15: r = 7'd25;
      5'd16: r = 7'd20; 5'd17: r = 7'd16; 5'd18: r = 7'd13; 5'd19: r = 7'd11;
      5'd20: r = 7'd10; 5'd21: r = 7'd9;  5'd22: r = 7'd8;  5'd23: r = 7'd7;
      5'd24: r = 7'd6;  5'd25: r = 7'd5;  5'd26: r = 7'd4;  5'd27: r = 7'd3;
      5'd28: r = 7'd2;  5'd29: r = 7'd1;  default: r = 7'd0;
    endcase
    return r;
  endfunction
endpackage

// File: rtl/core/ocvsoc_mv_conv.sv
// three-stage raw-sample to millivolt converter with stall enable
// depends on ocvsoc_pkg
module ocvsoc_mv_conv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [15:0]               raw_i,
  output logic [ocvsoc_pkg::MvW-1:0] mv_o
);
  import ocvsoc_pkg::*;

  // uv = raw*97656/1000 as (raw*12207)>>... exactly via reciprocal below
  // stage a: raw*97656 (33 bits)
  logic [32:0] prod_q;
  // stage b: uv = prod/1000
  logic [29:0] uv_q;
  logic [29:0] uv_d;
  logic [MvW-1:0] mv_d;

  // prod/1000 = (prod>>3)/125; prod>>3 < 2^30, reciprocal 2^37/125 rounded up
  logic [29:0] p8;
  logic [67:0] m1;
  logic [30:0] tv;
  logic [56:0] m2;

  always_comb begin
    p8   = prod_q[32:3];
    m1   = {38'd0, p8} * 68'd1099511628;
    uv_d = m1[66:37];
  end

  // mv = uv*3/1000 : tv = uv*3 < 2^25, /1000 via 2^41/1000 rounded up
  always_comb begin
    tv   = {1'b0, uv_q} * 31'd3;
    m2   = {26'd0, tv} * 57'd2199023256;
    mv_d = m2[MvW+40:41];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      uv_q   <= '0;
      mv_o   <= '0;
    end else if (en_i) begin
      prod_q <= {17'd0, raw_i} * 33'd97656;
      uv_q   <= uv_d;
      mv_o   <= mv_d;
    end
  end
endmodule

// File: rtl/core/ocv_voltage_to_charge_percent.sv
// top level: ocv table state-of-charge estimator, deep pipeline
// depends on ocvsoc_pkg, ocvsoc_mv_conv, assert_macros.svh
//
// One transaction in gives one transaction out. The pipe is eight stages deep
// (three for voltage conversion, selection, table search, interpolation
// multiply, divide, output) and takes a new item every cycle; a stall at the
// output holds the whole pipe. No clearing pass.
`include "assert_macros.svh"
module ocv_voltage_to_charge_percent (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // live_sample[15:0], live_ok[16], rest_sample[32:17], rest_ok[33],
  // charger_present[34], charger_ok[35], zero fill to 40
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // source[1:0], millivolts[16:2], percent[23:17], charging[25:24], fill to 32
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [14:0] cfg_wdata_i
);
  import ocvsoc_pkg::*;

  localparam int Depth = 8;
  localparam int QuotW = 3;

  logic en;
  logic [Depth-1:0] vld_q;
  logic [MvW-1:0] min_q, max_q;

  assign en = m_axis_tready || !vld_q[Depth-1];
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 15'd2500;
      max_q <= 15'd4600;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_MIN) min_q <= cfg_wdata_i;
      else max_q <= cfg_wdata_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  // flag delay through the three conversion stages
  logic [3:0] flg_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      flg_q[0] <= {s_axis_tdata[35], s_axis_tdata[34], s_axis_tdata[33], s_axis_tdata[16]};
      flg_q[1] <= flg_q[0];
      flg_q[2] <= flg_q[1];
    end
  end

  logic [MvW-1:0] live_mv, rest_mv;
  ocvsoc_mv_conv u_live (.clk_i, .rst_ni, .en_i(en), .raw_i(s_axis_tdata[15:0]),
                         .mv_o(live_mv));
  ocvsoc_mv_conv u_rest (.clk_i, .rst_ni, .en_i(en), .raw_i(s_axis_tdata[32:17]),
                         .mv_o(rest_mv));

  // stage 4: source selection
  stage_t s4_d, s4_q;
  logic live_pl, rest_pl;
  always_comb begin
    live_pl = flg_q[2][0] && live_mv >= min_q && live_mv <= max_q;
    rest_pl = flg_q[2][1] && rest_mv >= min_q && rest_mv <= max_q;
    s4_d.chg_present = flg_q[2][2];
    s4_d.chg_ok      = flg_q[2][3];
    if (live_pl) begin
      s4_d.source = SRC_LIVE; s4_d.mv = live_mv;
    end else if (rest_pl) begin
      s4_d.source = SRC_REST; s4_d.mv = rest_mv;
    end else begin
      s4_d.source = SRC_NONE; s4_d.mv = '0;
    end
  end

  // stage 5: segment search (compare against all rows in parallel)
  stage_t s5_q;
  logic [4:0] idx_d, idx_q;
  logic [1:0] clmp_d, clmp_q; // 0 interp, 1 top, 2 bottom
  always_comb begin
    idx_d  = 5'(TableRows - 1);
    clmp_d = 2'd0;
    for (int i = TableRows - 1; i >= 1; i--) begin
      if (s4_q.mv >= row_mv(5'(i))) idx_d = 5'(i);
    end
    if (s4_q.mv >= row_mv(5'd0)) clmp_d = 2'd1;
    else if (s4_q.mv <= row_mv(5'(TableRows - 1))) clmp_d = 2'd2;
  end

  // stage 6: numerator = (mv-vlo)*(phi-plo) + span/2
  stage_t s6_q;
  logic [1:0] clmp6_q;
  logic [PctW-1:0] plo6_q;
  logic [19:0] num_q;
  logic [9:0] span_q;
  logic [9:0] span_d;
  logic [19:0] num_d;
  always_comb begin
    span_d = 10'(row_mv(idx_q - 5'd1) - row_mv(idx_q));
    num_d  = 20'(s5_q.mv - row_mv(idx_q))
           * 20'(row_pct(idx_q - 5'd1) - row_pct(idx_q)) + 20'(span_d >> 1);
  end

  // stage 7: divide by span (rows step at most five percent: quotient under 8)
  stage_t s7_q;
  logic [PctW-1:0] pct7_d, pct7_q;
  logic [QuotW-1:0] q;
  logic [19:0] rem;
  always_comb begin
    rem = num_q;
    q   = '0;
    for (int b = QuotW - 1; b >= 0; b--) begin
      if (rem >= (20'(span_q) << b)) begin
        rem = rem - (20'(span_q) << b);
        q[b] = 1'b1;
      end
    end
    if (s6_q.source == SRC_NONE || clmp6_q == 2'd2) pct7_d = '0;
    else if (clmp6_q == 2'd1) pct7_d = 7'd100;
    else pct7_d = plo6_q + PctW'(q);
  end

  // stage 8: charging flag and output register
  logic [1:0] chg_d;
  logic [31:0] out_q;
  always_comb begin
    if (!s7_q.chg_ok) chg_d = CHG_FAIL;
    else if (!s7_q.chg_present) chg_d = CHG_OFF;
    else if (s7_q.source != SRC_NONE && pct7_q < 7'd100) chg_d = CHG_ON;
    else chg_d = CHG_OFF;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q    <= s4_d;
      s5_q    <= s4_q;
      idx_q   <= idx_d;
      clmp_q  <= clmp_d;
      s6_q    <= s5_q;
      clmp6_q <= clmp_q;
      plo6_q  <= row_pct(idx_q);
      num_q   <= num_d;
      span_q  <= span_d;
      s7_q    <= s6_q;
      pct7_q  <= pct7_d;
      out_q   <= {6'd0, chg_d, pct7_q, s7_q.mv, s7_q.source};
    end
  end

  assign m_axis_tdata = out_q;

  `ASSERT_IMPL(a_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_NEVER(a_pct_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[23:17] > 7'd100)
  `ASSERT_NEVER(a_none_zero, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] == SRC_NONE && m_axis_tdata[16:2] != 15'd0)
endmodule
